[src/pket_pkg.sv]
// Shared constants, codes and state type for the parent-keyed table engine.
`default_nettype none

package pket_pkg;

    // Default sizes
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_BITS_DEF  = 32;
    localparam int INFO_BITS_DEF = 32;

    // Largest number of result items one search may give
    localparam int RESULT_CAP = 16;
    localparam int CNT_W      = $clog2(RESULT_CAP);

    // Command codes
    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_ERASE  = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_MATCH = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    // Sequencer states, one-hot
    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_DECODE    = 12'b0000_0000_0010,
        ST_SRCH_RD   = 12'b0000_0000_0100,
        ST_SRCH_CHK  = 12'b0000_0000_1000,
        ST_SRCH_END  = 12'b0000_0001_0000,
        ST_ERS_RD    = 12'b0000_0010_0000,
        ST_ERS_CHK   = 12'b0000_0100_0000,
        ST_CASC_PICK = 12'b0000_1000_0000,
        ST_CASC_KEY  = 12'b0001_0000_0000,
        ST_CASC_RD   = 12'b0010_0000_0000,
        ST_CASC_CHK  = 12'b0100_0000_0000
    } state_t;

endpackage

`default_nettype wire

[src/parent_keyed_table_engine_top.sv]
// Parent-keyed table engine: slot table, read-then-check scan sequencer, result register.
// A new command is taken only while the sequencer is idle, and a stalled result holds
//   the sequencer.
// Reset: valid bits and control clear at once; entry contents are not cleared and are
//   used only from slots that hold or held an entry, so no clearing pass is needed.
`default_nettype none

module parent_keyed_table_engine_top #(
    parameter int DEPTH     = pket_pkg::DEPTH_DEF,
    parameter int KEY_BITS  = pket_pkg::KEY_BITS_DEF,
    parameter int INFO_BITS = pket_pkg::INFO_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] key,
    input  wire logic [31:0] parent_key,
    input  wire logic [31:0] info_word,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      out_key,
    output logic [31:0]      out_parent,
    output logic [31:0]      out_info,
    output logic             last
);

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int ENTRY_W = 2 * KEY_BITS + INFO_BITS;

    // Control registers
    pket_pkg::state_t                state_reg, state_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [pket_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [1:0]                      cmd_reg, cmd_next;
    logic [DEPTH-1:0]                valid_reg, valid_next;
    logic [DEPTH-1:0]                pend_reg, pend_next;
    logic                            hold_valid_reg, hold_valid_next;
    logic                            out_valid_reg, out_valid_next;

    // Payload registers
    logic [KEY_BITS-1:0]             cmp_key_reg, cmp_key_next;
    logic [KEY_BITS-1:0]             new_key_reg, new_key_next;
    logic [KEY_BITS-1:0]             new_par_reg, new_par_next;
    logic [INFO_BITS-1:0]            new_info_reg, new_info_next;
    logic [31:0]                     hold_key_reg, hold_key_next;
    logic [31:0]                     hold_par_reg, hold_par_next;
    logic [31:0]                     hold_info_reg, hold_info_next;
    logic [1:0]                      out_status_reg, out_status_next;
    logic [31:0]                     out_key_reg, out_key_next;
    logic [31:0]                     out_par_reg, out_par_next;
    logic [31:0]                     out_info_reg, out_info_next;
    logic                            out_last_reg, out_last_next;

    // Entry memory
    logic [ENTRY_W-1:0]              mem [DEPTH];
    logic [ENTRY_W-1:0]              rd_data_reg;
    logic [IDX_W-1:0]                rd_addr;
    logic                            mem_we;
    logic [IDX_W-1:0]                wr_addr;
    logic [ENTRY_W-1:0]              wr_data;

    logic [KEY_BITS-1:0]             rd_key, rd_par, cmp_op;
    logic [INFO_BITS-1:0]            rd_info;
    logic                            cmp_eq, slot_hit, idx_end, out_free, in_fire;
    logic                            tbl_empty, tbl_full;
    logic [IDX_W-1:0]                free_idx, pend_idx;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != pket_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign tbl_empty = (valid_reg == '0);
    assign tbl_full  = (valid_reg == '1);
    assign idx_end   = (idx_reg == IDX_W'(DEPTH - 1));

    // Fields of the slot read last cycle
    assign rd_key  = rd_data_reg[ENTRY_W-1 -: KEY_BITS];
    assign rd_par  = rd_data_reg[INFO_BITS +: KEY_BITS];
    assign rd_info = rd_data_reg[INFO_BITS-1:0];

    // Shared key comparator: erase scan matches keys, search and cascade match parents
    assign cmp_op   = (state_reg == pket_pkg::ST_ERS_CHK) ? rd_key : rd_par;
    assign cmp_eq   = (cmp_op == cmp_key_reg);
    assign slot_hit = valid_reg[idx_reg] && cmp_eq;

    // Lowest free slot and lowest slot waiting for its children to be removed
    always_comb
    begin
        free_idx = '0;
        pend_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
            if (pend_reg[i])
                pend_idx = IDX_W'(i);
        end
    end

    assign rd_addr = (state_reg == pket_pkg::ST_CASC_PICK) ? pend_idx : idx_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        valid_next      = valid_reg;
        pend_next       = pend_reg;
        hold_valid_next = hold_valid_reg;
        cmp_key_next    = cmp_key_reg;
        new_key_next    = new_key_reg;
        new_par_next    = new_par_reg;
        new_info_next   = new_info_reg;
        hold_key_next   = hold_key_reg;
        hold_par_next   = hold_par_reg;
        hold_info_next  = hold_info_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_par_next    = out_par_reg;
        out_info_next   = out_info_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_we          = 1'b0;
        wr_addr         = free_idx;
        wr_data         = {new_key_reg, new_par_reg, new_info_reg};

        case (state_reg)
            pket_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next      = cmd;
                    cmp_key_next  = (cmd == pket_pkg::CMD_ERASE) ? KEY_BITS'(key)
                                                                 : KEY_BITS'(parent_key);
                    new_key_next  = KEY_BITS'(key);
                    new_par_next  = KEY_BITS'(parent_key);
                    new_info_next = INFO_BITS'(info_word);
                    state_next    = pket_pkg::ST_DECODE;
                end
            end

            pket_pkg::ST_DECODE:
            begin
                idx_next = '0;
                cnt_next = '0;
                case (cmd_reg)
                    pket_pkg::CMD_SEARCH, pket_pkg::CMD_ERASE:
                    begin
                        if (!tbl_empty)
                            state_next = (cmd_reg == pket_pkg::CMD_SEARCH)
                                         ? pket_pkg::ST_SRCH_RD : pket_pkg::ST_ERS_RD;
                        else if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = pket_pkg::STAT_EMPTY;
                            out_key_next    = '0;
                            out_par_next    = '0;
                            out_info_next   = '0;
                            out_last_next   = 1'b1;
                            state_next      = pket_pkg::ST_IDLE;
                        end
                    end
                    pket_pkg::CMD_INSERT:
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_key_next    = 32'(new_key_reg);
                            out_par_next    = 32'(new_par_reg);
                            out_info_next   = 32'(new_info_reg);
                            out_last_next   = 1'b1;
                            if (tbl_full)
                                out_status_next = pket_pkg::STAT_FULL;
                            else
                            begin
                                out_status_next      = pket_pkg::STAT_OK;
                                mem_we               = 1'b1;
                                valid_next[free_idx] = 1'b1;
                            end
                            state_next = pket_pkg::ST_IDLE;
                        end
                    end
                    default:
                        state_next = pket_pkg::ST_IDLE;
                endcase
            end

            // Search: one match is held back until the next one shows whether it is the last
            pket_pkg::ST_SRCH_RD:
                state_next = pket_pkg::ST_SRCH_CHK;

            pket_pkg::ST_SRCH_CHK:
            begin
                if (slot_hit)
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = pket_pkg::STAT_OK;
                            out_key_next    = hold_key_reg;
                            out_par_next    = hold_par_reg;
                            out_info_next   = hold_info_reg;
                            out_last_next   = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_key_next   = 32'(rd_key);
                        hold_par_next   = 32'(rd_par);
                        hold_info_next  = 32'(rd_info);
                        cnt_next        = cnt_reg + 1'b1;
                        if (idx_end || cnt_reg == pket_pkg::CNT_W'(pket_pkg::RESULT_CAP - 1))
                            state_next = pket_pkg::ST_SRCH_END;
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = pket_pkg::ST_SRCH_RD;
                        end
                    end
                end
                else if (idx_end)
                    state_next = pket_pkg::ST_SRCH_END;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = pket_pkg::ST_SRCH_RD;
                end
            end

            pket_pkg::ST_SRCH_END:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_status_next = hold_valid_reg ? pket_pkg::STAT_OK
                                                     : pket_pkg::STAT_NO_MATCH;
                    out_key_next    = hold_valid_reg ? hold_key_reg  : '0;
                    out_par_next    = hold_valid_reg ? hold_par_reg  : '0;
                    out_info_next   = hold_valid_reg ? hold_info_reg : '0;
                    hold_valid_next = 1'b0;
                    state_next      = pket_pkg::ST_IDLE;
                end
            end

            // Erase: find lowest slot holding the key
            pket_pkg::ST_ERS_RD:
                state_next = pket_pkg::ST_ERS_CHK;

            pket_pkg::ST_ERS_CHK:
            begin
                if (slot_hit)
                begin
                    if (out_free)
                    begin
                        out_valid_next      = 1'b1;
                        out_status_next     = pket_pkg::STAT_OK;
                        out_key_next        = 32'(rd_key);
                        out_par_next        = 32'(rd_par);
                        out_info_next       = 32'(rd_info);
                        out_last_next       = 1'b1;
                        valid_next[idx_reg] = 1'b0;
                        pend_next[idx_reg]  = 1'b1;
                        state_next          = pket_pkg::ST_CASC_PICK;
                    end
                end
                else if (idx_end)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = pket_pkg::STAT_NO_MATCH;
                        out_key_next    = '0;
                        out_par_next    = '0;
                        out_info_next   = '0;
                        out_last_next   = 1'b1;
                        state_next      = pket_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = pket_pkg::ST_ERS_RD;
                end
            end

            // Cascade: take one removed slot, remove every valid child of its key
            pket_pkg::ST_CASC_PICK:
            begin
                if (pend_reg == '0)
                    state_next = pket_pkg::ST_IDLE;
                else
                begin
                    pend_next[pend_idx] = 1'b0;
                    state_next          = pket_pkg::ST_CASC_KEY;
                end
            end

            pket_pkg::ST_CASC_KEY:
            begin
                cmp_key_next = rd_key;
                idx_next     = '0;
                state_next   = pket_pkg::ST_CASC_RD;
            end

            pket_pkg::ST_CASC_RD:
                state_next = pket_pkg::ST_CASC_CHK;

            pket_pkg::ST_CASC_CHK:
            begin
                if (slot_hit)
                begin
                    valid_next[idx_reg] = 1'b0;
                    pend_next[idx_reg]  = 1'b1;
                end
                if (idx_end)
                    state_next = pket_pkg::ST_CASC_PICK;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = pket_pkg::ST_CASC_RD;
                end
            end

            default:
                state_next = pket_pkg::ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pket_pkg::ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            cmd_reg        <= '0;
            valid_reg      <= '0;
            pend_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            cmd_reg        <= cmd_next;
            valid_reg      <= valid_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmp_key_reg    <= cmp_key_next;
        new_key_reg    <= new_key_next;
        new_par_reg    <= new_par_next;
        new_info_reg   <= new_info_next;
        hold_key_reg   <= hold_key_next;
        hold_par_reg   <= hold_par_next;
        hold_info_reg  <= hold_info_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_par_reg    <= out_par_next;
        out_info_reg   <= out_info_next;
        out_last_reg   <= out_last_next;
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign out_key    = out_key_reg;
    assign out_parent = out_par_reg;
    assign out_info   = out_info_reg;
    assign last       = out_last_reg;

    // A slot waiting in the cascade has already been removed
    a_pend_not_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & valid_reg) == '0)
        else $error("cascade slot still valid");

    // Removals wait only inside the cascade
    a_pend_in_casc: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != '0 |-> (state_reg == pket_pkg::ST_CASC_PICK
                            || state_reg == pket_pkg::ST_CASC_KEY
                            || state_reg == pket_pkg::ST_CASC_RD
                            || state_reg == pket_pkg::ST_CASC_CHK))
        else $error("pending removal outside cascade");

    // A held match exists only while a search runs
    a_hold_in_srch: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (state_reg == pket_pkg::ST_SRCH_RD
                            || state_reg == pket_pkg::ST_SRCH_CHK
                            || state_reg == pket_pkg::ST_SRCH_END))
        else $error("held match outside search");

    // Only an insert adds valid slots
    a_grow_on_ins: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) > $countones($past(valid_reg))
            |-> $past(state_reg == pket_pkg::ST_DECODE && cmd_reg == pket_pkg::CMD_INSERT))
        else $error("valid slots grew outside insert");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the parent-keyed table engine: search, cascaded erase and insert.
`timescale 1ns / 100ps

module tb_top;

    localparam int          SLOTS       = pket_pkg::DEPTH_DEF;
    localparam logic [1:0]  CMD_NONE    = 2'd3;    // undefined command, dropped by the block
    localparam int          IDLE_PCT    = 18;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          RAND_ITEMS  = 70;
    localparam logic [31:0] TREE_ROOT   = 32'h0000_C0DE;
    localparam logic [31:0] POOL_BASE   = 32'h0000_7000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] parent;
        logic [31:0] info;
    } table_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] key;
        logic [31:0] parent;
        logic [31:0] info;
        logic        last;
    } table_result_t;

    // DUT connections
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd        = '0;
    logic [31:0] key        = '0;
    logic [31:0] parent_key = '0;
    logic [31:0] info_word  = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [1:0]  status;
    logic [31:0] out_key;
    logic [31:0] out_parent;
    logic [31:0] out_info;
    logic        last;

    // Mirror of the slot table
    logic        tbl_valid  [SLOTS];
    logic [31:0] tbl_key    [SLOTS];
    logic [31:0] tbl_parent [SLOTS];
    logic [31:0] tbl_info   [SLOTS];

    table_cmd_t    cmd_backlog     [$];
    table_result_t pending_results [$];
    logic [31:0]   known_keys      [$];

    bit   cmd_fire   = 1'b0;
    int   cycle_cnt  = 0;
    int   hold_left  = 0;
    int   holds_done = 0;
    int   err_cnt    = 0;
    int   n_queued   = 0;
    int   n_taken    = 0;
    int   n_results  = 0;
    int   n_search   = 0;
    int   n_erase    = 0;
    int   n_insert   = 0;
    int   n_ignored  = 0;
    int   n_full     = 0;
    int   n_cascade  = 0;
    int   max_hits   = 0;
    logic quiet;

    parent_keyed_table_engine_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .key        (key),
        .parent_key (parent_key),
        .info_word  (info_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_key    (out_key),
        .out_parent (out_parent),
        .out_info   (out_info),
        .last       (last)
    );

    always #6 clk = ~clk;

    // No random idling on either side inside this window
    assign quiet = (cycle_cnt >= 1000) && (cycle_cnt < 2000);

    // Work out the results of one accepted command and update the mirror
    task automatic apply_table_cmd(input table_cmd_t c);
        table_result_t r;
        logic [31:0]   gone [$];
        int            hit;
        int            hits;
        int            n;
        bit            any;
        bit            changed;
        bit            found;
        r      = '0;
        r.last = 1'b1;
        any    = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            any |= tbl_valid[i];
        case (c.op)
            pket_pkg::CMD_SEARCH:
            begin
                n_search++;
                hits = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_valid[i] && tbl_parent[i] == c.parent)
                        hits++;
                if (hits > pket_pkg::RESULT_CAP)
                    hits = pket_pkg::RESULT_CAP;
                if (!any)
                begin
                    r.status = pket_pkg::STAT_EMPTY;
                    pending_results.push_back(r);
                end
                else if (hits == 0)
                begin
                    r.status = pket_pkg::STAT_NO_MATCH;
                    pending_results.push_back(r);
                end
                else
                begin
                    // one item per matching slot, in slot order
                    n = 0;
                    for (int i = 0; i < SLOTS && n < hits; i++)
                    begin
                        if (tbl_valid[i] && tbl_parent[i] == c.parent)
                        begin
                            n++;
                            r.status = pket_pkg::STAT_OK;
                            r.key    = tbl_key[i];
                            r.parent = tbl_parent[i];
                            r.info   = tbl_info[i];
                            r.last   = (n == hits);
                            pending_results.push_back(r);
                        end
                    end
                    if (hits > max_hits)
                        max_hits = hits;
                end
            end
            pket_pkg::CMD_ERASE:
            begin
                n_erase++;
                hit = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tbl_valid[i] && tbl_key[i] == c.key)
                        hit = i;
                if (!any)
                begin
                    r.status = pket_pkg::STAT_EMPTY;
                    pending_results.push_back(r);
                end
                else if (hit < 0)
                begin
                    r.status = pket_pkg::STAT_NO_MATCH;
                    pending_results.push_back(r);
                end
                else
                begin
                    r.status = pket_pkg::STAT_OK;
                    r.key    = tbl_key[hit];
                    r.parent = tbl_parent[hit];
                    r.info   = tbl_info[hit];
                    pending_results.push_back(r);
                    tbl_valid[hit] = 1'b0;
                    gone.push_back(tbl_key[hit]);
                    // cascade: drop children of any removed key until a pass removes nothing
                    do
                    begin
                        changed = 1'b0;
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (tbl_valid[i])
                            begin
                                found = 1'b0;
                                foreach (gone[j])
                                    if (tbl_parent[i] == gone[j])
                                        found = 1'b1;
                                if (found)
                                begin
                                    tbl_valid[i] = 1'b0;
                                    gone.push_back(tbl_key[i]);
                                    changed = 1'b1;
                                    n_cascade++;
                                end
                            end
                        end
                    end
                    while (changed);
                end
            end
            pket_pkg::CMD_INSERT:
            begin
                n_insert++;
                hit = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!tbl_valid[i])
                        hit = i;
                r.key    = c.key;
                r.parent = c.parent;
                r.info   = c.info;
                if (hit < 0)
                begin
                    r.status = pket_pkg::STAT_FULL;
                    n_full++;
                end
                else
                begin
                    r.status        = pket_pkg::STAT_OK;
                    tbl_valid[hit]  = 1'b1;
                    tbl_key[hit]    = c.key;
                    tbl_parent[hit] = c.parent;
                    tbl_info[hit]   = c.info;
                end
                pending_results.push_back(r);
            end
            default:
                n_ignored++;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%h, got 0x%h", name, want, got);
            err_cnt++;
        end
    endtask

    task automatic queue_cmd(input logic [1:0] op, input logic [31:0] k,
                             input logic [31:0] p, input logic [31:0] i);
        cmd_backlog.push_back(table_cmd_t'{op, k, p, i});
        n_queued++;
    endtask

    // Mostly a small key pool so that duplicates and parent links occur
    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return POOL_BASE + $urandom_range(0, 15);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_known();
        if (known_keys.size() != 0 && $urandom_range(0, 4) != 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        return pick_key();
    endfunction

    // Cycle count and timeout
    always @(posedge clk)
    begin : count_cycles
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Command driver: a new item only once the previous one has been taken
    always @(negedge clk)
    begin : drive_cmds
        table_cmd_t nxt;
        if (rst_n && (!in_valid || cmd_fire))
        begin
            if (cmd_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt = cmd_backlog.pop_front();
                in_valid   <= 1'b1;
                cmd        <= nxt.op;
                key        <= nxt.key;
                parent_key <= nxt.parent;
                info_word  <= nxt.info;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result stall: random, plus two long hold-offs while commands are still waiting
    always @(negedge clk)
    begin : drive_stall
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (rst_n && holds_done < 2 && cmd_backlog.size() != 0
                 && cycle_cnt >= ((holds_done == 0) ? 700 : 4000))
        begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Accepted commands feed the mirror; accepted results are checked in order
    always @(posedge clk)
    begin : watch
        table_result_t want;
        cmd_fire = rst_n && in_valid && !in_stall;
        if (cmd_fire)
        begin
            n_taken++;
            apply_table_cmd(table_cmd_t'{cmd, key, parent_key, info_word});
        end
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d key 0x%h", status, out_key);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("out_key", want.key, out_key);
                check_field("out_parent", want.parent, out_parent);
                check_field("out_info", want.info, out_info);
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] k;
        logic [31:0] p;
        int          roll;
        int          made;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_valid[i]  = 1'b0;
            tbl_key[i]    = '0;
            tbl_parent[i] = '0;
            tbl_info[i]   = '0;
        end

        // Directed: empty table, ignored command, extreme values
        queue_cmd(pket_pkg::CMD_SEARCH, 32'h0, 32'h1234_5678, 32'h0);
        queue_cmd(pket_pkg::CMD_ERASE, 32'h1234_5678, 32'h0, 32'h0);
        queue_cmd(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(pket_pkg::CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0);
        queue_cmd(pket_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        queue_cmd(pket_pkg::CMD_SEARCH, 32'h0, 32'hFFFF_FFFF, 32'h0);
        queue_cmd(pket_pkg::CMD_SEARCH, 32'h0, 32'h0000_0BAD, 32'h0);
        // the two entries are each other's parent: cascade must stop
        queue_cmd(pket_pkg::CMD_ERASE, 32'h0, 32'h0, 32'h0);
        // fill the table under one parent, overflow it, then list all sixteen
        for (int i = 0; i < SLOTS; i++)
        begin
            queue_cmd(pket_pkg::CMD_INSERT, 32'h10 + i, TREE_ROOT, $urandom);
            known_keys.push_back(32'h10 + i);
        end
        queue_cmd(pket_pkg::CMD_INSERT, 32'h20, TREE_ROOT, 32'hA5A5_5A5A);
        queue_cmd(pket_pkg::CMD_SEARCH, 32'h0, TREE_ROOT, 32'h0);
        known_keys.push_back(TREE_ROOT);

        // Random: trees built from known keys, searched and pruned
        made = 0;
        while (made < RAND_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                queue_cmd(CMD_NONE, $urandom, $urandom, $urandom);
            else
            begin
                made++;
                if (roll < 50)
                begin
                    k = pick_key();
                    p = pick_known();
                    queue_cmd(pket_pkg::CMD_INSERT, k, p, $urandom);
                    known_keys.push_back(k);
                end
                else if (roll < 78)
                    queue_cmd(pket_pkg::CMD_SEARCH, $urandom, pick_known(), $urandom);
                else
                    queue_cmd(pket_pkg::CMD_ERASE, pick_known(), $urandom, $urandom);
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain
        wait (n_taken == n_queued);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4 * SLOTS + 8) @(posedge clk);

        $display("Commands: %0d searches, %0d erases, %0d inserts, %0d undefined; %0d results",
                 n_search, n_erase, n_insert, n_ignored, n_results);
        $display("Inserts into a full table: %0d, cascade removals: %0d, widest search: %0d",
                 n_full, n_cascade, max_hits);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
